// ----- hw/rtl/ssg_pkg.sv -----
`default_nettype none

package ssg_pkg;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] FIFTH_Q16 = 17'd13107;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned QUO_BITS    = 17;

  typedef enum logic [1:0] {
    CFG_INNER  = 2'd0,
    CFG_OUTER  = 2'd1,
    CFG_VOLUME = 2'd2
  } ssg_cfg_e;

  // front end -> square root
  typedef struct packed {
    logic [63:0] sq;
    logic        aud;
    logic        att1;
    logic        dsign;
    logic [49:0] dmag;
  } ssg_geo_t;

  // square root -> dividers
  typedef struct packed {
    logic [31:0] dlen;
    logic        aud;
    logic        att1;
    logic        dsign;
    logic [49:0] dmag;
  } ssg_rad_t;

  // dividers -> gain
  typedef struct packed {
    logic [16:0] qa;
    logic [16:0] qq;
    logic        sat;
    logic        aud;
    logic        att1;
    logic        dsign;
    logic        dzero;
  } ssg_quo_t;

  typedef struct packed {
    logic [19:0] left;
    logic [19:0] right;
    logic        aud;
  } ssg_gain_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssg_front.sv -----
`default_nettype none

module ssg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       src_x_i,
  input  logic [31:0]       src_y_i,
  input  logic [31:0]       src_z_i,
  input  logic [31:0]       lis_x_i,
  input  logic [31:0]       lis_y_i,
  input  logic [31:0]       lis_z_i,
  input  logic [15:0]       ear_x_i,
  input  logic [15:0]       ear_y_i,
  input  logic [15:0]       ear_z_i,
  input  logic [31:0]       inner_i,
  input  logic [31:0]       outer_i,
  output logic              valid_o,
  output ssg_pkg::ssg_geo_t geo_o
);
  import ssg_pkg::*;

  logic [31:0] src [3];
  logic [31:0] lis [3];
  logic [15:0] ear [3];

  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [32:0] d1_q   [3];
  logic        [31:0] mag1_q [3];
  logic signed [15:0] e1_q   [3];
  logic        [63:0] m2_q   [3];
  logic signed [48:0] p2_q   [3];
  logic        [63:0] osq2_q, isq2_q, osq3_q, isq3_q;
  logic        [65:0] sq3_q;
  logic signed [50:0] dot3_q;
  logic signed [50:0] dot_neg;
  ssg_geo_t           geo4_q;

  assign src = '{src_x_i, src_y_i, src_z_i};
  assign lis = '{lis_x_i, lis_y_i, lis_z_i};
  assign ear = '{ear_x_i, ear_y_i, ear_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: differences; magnitude fits 32 bits, so modular subtract is exact
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i]   <= $signed({lis[i][31], lis[i]}) - $signed({src[i][31], src[i]});
        mag1_q[i] <= ($signed(lis[i]) >= $signed(src[i])) ? (lis[i] - src[i])
                                                            : (src[i] - lis[i]);
        e1_q[i]   <= $signed(ear[i]);
      end
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m2_q[i] <= 64'(mag1_q[i]) * 64'(mag1_q[i]);
        p2_q[i] <= 49'(d1_q[i]) * 49'(e1_q[i]);
      end
      osq2_q <= 64'(outer_i) * 64'(outer_i);
      isq2_q <= 64'(inner_i) * 64'(inner_i);
    end
  end

  // stage 3: sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq3_q  <= {2'b00, m2_q[0]} + {2'b00, m2_q[1]} + {2'b00, m2_q[2]};
      dot3_q <= 51'(p2_q[0]) + 51'(p2_q[1]) + 51'(p2_q[2]);
      osq3_q <= osq2_q;
      isq3_q <= isq2_q;
    end
  end

  assign dot_neg = -dot3_q;

  // stage 4: range checks and dot magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo4_q.sq    <= sq3_q[63:0];
      geo4_q.aud   <= (sq3_q[65:64] == 2'b00) && (sq3_q[63:0] <= osq3_q);
      geo4_q.att1  <= (isq3_q > sq3_q[63:0]) || (outer_i <= inner_i);
      geo4_q.dsign <= dot3_q[50];
      geo4_q.dmag  <= dot3_q[50] ? dot_neg[49:0] : dot3_q[49:0];
    end
  end

  assign valid_o = v4_q;
  assign geo_o   = geo4_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ssg_sqrt.sv -----
`default_nettype none

module ssg_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ssg_pkg::ssg_geo_t geo_i,
  output logic              valid_o,
  output ssg_pkg::ssg_rad_t rad_o
);
  import ssg_pkg::*;

  // one root bit per stage, restoring digit recurrence
  logic        vld_q [SQRT_STAGES];
  logic [33:0] rem_q [SQRT_STAGES];
  logic [31:0] y_q   [SQRT_STAGES];
  ssg_geo_t    geo_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_st
    logic        vin;
    logic [33:0] rem_in;
    logic [31:0] y_in;
    ssg_geo_t    g_in;
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign rem_in = '0;
      assign y_in   = '0;
      assign g_in   = geo_i;
    end else begin : g_next
      assign vin    = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign y_in   = y_q[k-1];
      assign g_in   = geo_q[k-1];
    end

    assign cur   = {rem_in, g_in.sq[63-2*k -: 2]};
    assign trial = {2'b00, y_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 34'(cur - trial) : cur[33:0];
        y_q[k]   <= {y_in[30:0], ge};
        geo_q[k] <= g_in;
      end
    end
  end

  assign valid_o     = vld_q[SQRT_STAGES-1];
  assign rad_o.dlen  = y_q[SQRT_STAGES-1];
  assign rad_o.aud   = geo_q[SQRT_STAGES-1].aud;
  assign rad_o.att1  = geo_q[SQRT_STAGES-1].att1;
  assign rad_o.dsign = geo_q[SQRT_STAGES-1].dsign;
  assign rad_o.dmag  = geo_q[SQRT_STAGES-1].dmag;

endmodule

`default_nettype wire

// ----- hw/rtl/ssg_div.sv -----
`default_nettype none

module ssg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ssg_pkg::ssg_rad_t rad_i,
  input  logic [31:0]       inner_i,
  input  logic [31:0]       outer_i,
  output logic              valid_o,
  output ssg_pkg::ssg_quo_t quo_o
);
  import ssg_pkg::*;

  // partial remainder r stays below d; lo feeds one dividend bit per stage
  typedef struct packed {
    logic [31:0] r;
    logic [16:0] lo;
    logic [31:0] d;
    logic [16:0] q;
  } lane_t;

  typedef struct packed {
    logic sat;
    logic aud;
    logic att1;
    logic dsign;
    logic dzero;
  } side_t;

  logic [31:0] num;
  logic [51:0] nq;
  lane_t       a_set, b_set;
  side_t       s_set;

  logic        v0_q;
  lane_t       a0_q, b0_q;
  side_t       s0_q;

  logic        vld_q [QUO_BITS];
  lane_t       a_q   [QUO_BITS];
  lane_t       b_q   [QUO_BITS];
  side_t       s_q   [QUO_BITS];

  // attenuation: (outer - dist) * 2^16 / (outer - inner)
  // direction:   |dot| * 4 / dist, saturating at 2^17
  assign num = (outer_i > rad_i.dlen) ? (outer_i - rad_i.dlen) : '0;
  assign nq  = {rad_i.dmag, 2'b00};

  always_comb begin
    a_set.r   = {1'b0, num[31:1]};
    a_set.lo  = {num[0], 16'd0};
    a_set.d   = outer_i - inner_i;
    a_set.q   = '0;
    b_set.r   = nq[48:17];
    b_set.lo  = nq[16:0];
    b_set.d   = rad_i.dlen;
    b_set.q   = '0;
    s_set.sat   = nq[51:17] >= {3'b000, rad_i.dlen};
    s_set.aud   = rad_i.aud;
    s_set.att1  = rad_i.att1;
    s_set.dsign = rad_i.dsign;
    s_set.dzero = rad_i.dlen == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q <= a_set;
      b0_q <= b_set;
      s0_q <= s_set;
    end
  end

  function automatic lane_t div_step(lane_t l, logic [4:0] bit_idx);
    logic [32:0] cur;
    logic        ge;
    lane_t       o;
    cur = {l.r, l.lo[bit_idx]};
    ge  = cur >= {1'b0, l.d};
    o   = l;
    o.r = ge ? 32'(cur - {1'b0, l.d}) : cur[31:0];
    o.q = {l.q[15:0], ge};
    return o;
  endfunction

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_st
    logic  vin;
    lane_t a_in, b_in;
    side_t s_in;

    if (k == 0) begin : g_first
      assign vin  = v0_q;
      assign a_in = a0_q;
      assign b_in = b0_q;
      assign s_in = s0_q;
    end else begin : g_next
      assign vin  = vld_q[k-1];
      assign a_in = a_q[k-1];
      assign b_in = b_q[k-1];
      assign s_in = s_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k] <= div_step(a_in, 5'(QUO_BITS - 1 - k));
        b_q[k] <= div_step(b_in, 5'(QUO_BITS - 1 - k));
        s_q[k] <= s_in;
      end
    end
  end

  assign valid_o     = vld_q[QUO_BITS-1];
  assign quo_o.qa    = a_q[QUO_BITS-1].q;
  assign quo_o.qq    = b_q[QUO_BITS-1].q;
  assign quo_o.sat   = s_q[QUO_BITS-1].sat;
  assign quo_o.aud   = s_q[QUO_BITS-1].aud;
  assign quo_o.att1  = s_q[QUO_BITS-1].att1;
  assign quo_o.dsign = s_q[QUO_BITS-1].dsign;
  assign quo_o.dzero = s_q[QUO_BITS-1].dzero;

endmodule

`default_nettype wire

// ----- hw/rtl/ssg_gain.sv -----
`default_nettype none

module ssg_gain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ssg_pkg::ssg_quo_t  quo_i,
  input  logic [15:0]        volume_i,
  output logic               valid_o,
  output ssg_pkg::ssg_gain_t gain_o
);
  import ssg_pkg::*;

  // presence for a positive direction term, clamped to 0.2..1
  function automatic logic [16:0] presence(logic [16:0] q);
    logic [16:0] p;
    p = (q >= ONE_Q16) ? 17'd0 : (ONE_Q16 - q);
    return (p < FIFTH_Q16) ? FIFTH_Q16 : p;
  endfunction

  logic [16:0] att, qc, pl, pr;
  logic        nz;

  logic        v1_q, v2_q, v3_q;
  logic [16:0] att1_q, pl1_q, pr1_q, pl2_q, pr2_q;
  logic        aud1_q, aud2_q;
  logic [32:0] av2_q;
  logic [49:0] gl, gr;
  ssg_gain_t   g3_q;

  always_comb begin
    att = quo_i.att1 ? ONE_Q16 : quo_i.qa;
    qc  = quo_i.sat ? ONE_Q16 : quo_i.qq;
    nz  = !quo_i.dzero && (qc != '0);
    pr  = (nz && !quo_i.dsign) ? presence(qc) : ONE_Q16;
    pl  = (nz && quo_i.dsign)  ? presence(qc) : ONE_Q16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign gl = 50'(av2_q) * 50'(pl2_q);
  assign gr = 50'(av2_q) * 50'(pr2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      att1_q <= att;
      pl1_q  <= pl;
      pr1_q  <= pr;
      aud1_q <= quo_i.aud;

      av2_q  <= 33'(att1_q) * 33'(volume_i);
      pl2_q  <= pl1_q;
      pr2_q  <= pr1_q;
      aud2_q <= aud1_q;

      g3_q.left  <= aud2_q ? gl[48:29] : '0;
      g3_q.right <= aud2_q ? gr[48:29] : '0;
      g3_q.aud   <= aud2_q;
    end
  end

  assign valid_o = v3_q;
  assign gain_o  = g3_q;

endmodule

`default_nettype wire

// ----- hw/rtl/spatial_stereo_gain_core.sv -----
`default_nettype none

// Distance attenuation and stereo pan for one sound source. Each input word
// carries source and listener positions (Q16.16) and the right-ear unit vector
// (Q2.14); each output word carries left and right gains (Q5.15) and the
// audible flag in tuser. One word in and one word out per clock while the sink
// is ready. It has 4 front-end stages (difference, square/dot multipliers, sums,
// range compare), 32 square-root stages at one root bit each, 18 divider stages
// (setup plus one quotient bit each, attenuation and direction dividers side by
// side), 3 gain stages, and a two-word output buffer that keeps the pipeline
// moving while a word waits. The user must write registers through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; not enforced by the block.
module spatial_stereo_gain_core (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // source_x, source_y, source_z, listener_x, listener_y, listener_z,
  // ear_x, ear_y, ear_z
  input  logic [239:0] s_axis_tdata,

  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_gain, right_gain
  output logic [39:0]  m_axis_tdata,
  // audible
  output logic         m_axis_tuser,

  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);
  import ssg_pkg::*;

  logic [31:0] inner_q, outer_q;
  logic [15:0] volume_q;

  logic        en;
  logic        f_vld, s_vld, d_vld, g_vld;
  ssg_geo_t    geo;
  ssg_rad_t    rad;
  ssg_quo_t    quo;
  ssg_gain_t   gain;

  logic [1:0]  cnt_q;
  ssg_gain_t   head_q, spare_q;
  logic        push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q  <= 32'd65536;
      outer_q  <= 32'd655360;
      volume_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (ssg_cfg_e'(cfg_idx_i))
        CFG_INNER:  inner_q  <= cfg_wdata_i;
        CFG_OUTER:  outer_q  <= cfg_wdata_i;
        CFG_VOLUME: volume_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the output buffer has room or is draining
  assign en            = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = en;

  ssg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .src_x_i (s_axis_tdata[31:0]),
    .src_y_i (s_axis_tdata[63:32]),
    .src_z_i (s_axis_tdata[95:64]),
    .lis_x_i (s_axis_tdata[127:96]),
    .lis_y_i (s_axis_tdata[159:128]),
    .lis_z_i (s_axis_tdata[191:160]),
    .ear_x_i (s_axis_tdata[207:192]),
    .ear_y_i (s_axis_tdata[223:208]),
    .ear_z_i (s_axis_tdata[239:224]),
    .inner_i (inner_q),
    .outer_i (outer_q),
    .valid_o (f_vld),
    .geo_o   (geo)
  );

  ssg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .geo_i   (geo),
    .valid_o (s_vld),
    .rad_o   (rad)
  );

  ssg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld),
    .rad_i   (rad),
    .inner_i (inner_q),
    .outer_i (outer_q),
    .valid_o (d_vld),
    .quo_o   (quo)
  );

  ssg_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (d_vld),
    .quo_i    (quo),
    .volume_i (volume_q),
    .valid_o  (g_vld),
    .gain_o   (gain)
  );

  assign push = en && g_vld;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && cnt_q == 2'd1) begin
        head_q <= gain;
      end else begin
        head_q <= spare_q;
      end
      if (push && cnt_q == 2'd2) begin
        spare_q <= gain;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        head_q <= gain;
      end else begin
        spare_q <= gain;
      end
    end
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {head_q.right, head_q.left};
  assign m_axis_tuser  = head_q.aud;

endmodule

`default_nettype wire

// ----- dv/ssg_checker.sv -----
`timescale 1ns / 100ps

module ssg_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [239:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [39:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  output int           fail_count_o,
  output int           pending_o
);
  import ssg_pkg::*;

  typedef struct packed {
    logic [19:0] left;
    logic [19:0] right;
    logic        aud;
  } gain_word_t;

  logic [31:0] inner_r, outer_r;
  logic [15:0] vol_g;
  // expected words in order; far deeper than the pipeline
  gain_word_t  exp_mem [1024];
  int          wr_cnt = 0;
  int          rd_cnt = 0;

  assign pending_o = wr_cnt - rd_cnt;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] ear_presence(logic signed [63:0] q);
    logic [63:0] p;
    if (q <= 0) return 64'd65536;
    p = (q >= 65536) ? 64'd0 : 64'd65536 - q;
    return (p < 13107) ? 64'd13107 : p;
  endfunction

  function automatic gain_word_t predict_gain(logic [239:0] w);
    logic signed [63:0] d[3];
    logic signed [63:0] e[3];
    logic signed [63:0] dotraw, q;
    logic [63:0] m, s, sq, dlen, att, num, pl, pr, qm, o64, i64;
    logic [127:0] pw;
    int carry;
    gain_word_t r;
    sq = 0; carry = 0; dotraw = 0;
    o64 = outer_r; i64 = inner_r;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed(w[96+32*i +: 32]) - $signed(w[32*i +: 32]);
      e[i] = $signed(w[192+16*i +: 16]);
      m = (d[i] < 0) ? -d[i] : d[i];
      s = m * m;
      sq = sq + s;
      if (sq < s) carry++;
      dotraw = dotraw + d[i] * e[i];
    end
    r = '0;
    if (carry != 0 || sq > o64 * o64) return r;
    dlen = root64(sq);
    if (i64 * i64 > sq || o64 <= i64) begin
      att = 65536;
    end else begin
      num = (o64 > dlen) ? o64 - dlen : 0;
      att = (num << 16) / (o64 - i64);
      if (att > 65536) att = 65536;
    end
    if (dlen == 0) begin
      pl = 65536; pr = 65536;
    end else begin
      m = (dotraw < 0) ? -dotraw : dotraw;
      qm = (m << 2) / dlen;
      q = (dotraw < 0) ? -$signed(qm) : $signed(qm);
      pr = ear_presence(q);
      pl = ear_presence(-q);
    end
    pw = 128'(att) * vol_g * pl;
    r.left = pw[48:29];
    pw = 128'(att) * vol_g * pr;
    r.right = pw[48:29];
    r.aud = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gain_word_t exp_w;
    if (!rst_ni) begin
      inner_r <= 32'd65536;
      outer_r <= 32'd655360;
      vol_g <= 16'd4096;
      fail_count_o = 0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_mem[wr_cnt[9:0]] = predict_gain(s_axis_tdata);
        wr_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_cnt == rd_cnt) begin
          report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
        end else begin
          exp_w = exp_mem[rd_cnt[9:0]];
          rd_cnt++;
          if (m_axis_tdata[19:0] != exp_w.left)
            report_mismatch("left_gain", 32'(m_axis_tdata[19:0]), 32'(exp_w.left));
          if (m_axis_tdata[39:20] != exp_w.right)
            report_mismatch("right_gain", 32'(m_axis_tdata[39:20]), 32'(exp_w.right));
          if (m_axis_tuser != exp_w.aud)
            report_mismatch("audible", 32'(m_axis_tuser), 32'(exp_w.aud));
        end
      end
      if (cfg_we_i) begin
        unique case (ssg_cfg_e'(cfg_idx_i))
          CFG_INNER:  inner_r <= cfg_wdata_i;
          CFG_OUTER:  outer_r <= cfg_wdata_i;
          CFG_VOLUME: vol_g <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- dv/tb_spatial_stereo_gain_core.sv -----
`timescale 1ns / 100ps

module tb_spatial_stereo_gain_core;
  import ssg_pkg::*;

  localparam int LATENCY = 70;
  localparam int WATCH_LIMIT = 4000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = CFG_INNER;
  logic [31:0]  cfg_wdata_i = '0;
  int           fail_count, pending;
  bit           calm = 0;
  int           idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  spatial_stereo_gain_core DUT (.*);

  ssg_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // sink stalls in bursts
  always begin
    int n;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // leaves tvalid high so words can follow back to back; drain drops it
  task automatic send_word(logic [239:0] w);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [239:0] pack_word(logic [31:0] sx, logic [31:0] sy,
      logic [31:0] sz, logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
      logic [15:0] ex, logic [15:0] ey, logic [15:0] ez);
    return {ez, ey, ex, lz, ly, lx, sz, sy, sx};
  endfunction

  task automatic write_reg(ssg_cfg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_ear();
    int v;
    v = $urandom_range(0, 32768);
    return 16'(v - 16384);
  endfunction

  // near positions: small offsets around a random listener
  function automatic logic [239:0] near_word(int span);
    logic [31:0] lx, ly, lz;
    lx = $urandom_range(0, 1 << 22) - (1 << 21);
    ly = $urandom;
    lz = $urandom_range(0, 1 << 22);
    return pack_word(lx + $urandom_range(0, span) - span / 2,
                     ly + $urandom_range(0, span) - span / 2,
                     lz + $urandom_range(0, span) - span / 2,
                     lx, ly, lz, rand_ear(), rand_ear(), rand_ear());
  endfunction

  initial begin
    logic [239:0] w;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: zero distance, axis cases, extremes, radius edges
    send_word('0);
    send_word(pack_word(0, 0, 0, 32'h0001_0000, 0, 0, 16'd16384, 0, 0));
    send_word(pack_word(0, 0, 0, 32'h0001_0000, 0, 0, -16'sd16384, 0, 0));
    send_word(pack_word(0, 0, 0, 0, 32'h0005_0000, 0, 0, 16'd16384, 0));
    send_word(pack_word(0, 0, 0, 32'h000a_0000, 0, 0, 0, 0, 16'd16384));
    send_word(pack_word(0, 0, 0, 32'h000a_0001, 0, 0, 16'd16384, 0, 0));
    send_word(pack_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        16'hffff, 16'hffff, 16'hffff));
    send_word(pack_word(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0,
                        16'h7fff, 16'h8000, 16'h4000));
    send_word(pack_word(32'h0000_8000, 0, 0, 0, 0, 0,
                        -16'sd16384, -16'sd16384, -16'sd16384));
    send_word(pack_word(0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0,
                        16'd8000, -16'sd9000, 16'd100));
    drain();

    write_reg(CFG_VOLUME, 32'h0000_ffff);
    write_reg(CFG_INNER, 32'd0);
    write_reg(CFG_OUTER, 32'hffff_ffff);
    send_word(pack_word(0, 0, 0, 32'h1000_0000, 0, 0, 16'd100, 0, 0));
    send_word(pack_word(0, 0, 0, 32'h7fff_0000, 32'h7fff_0000, 0, 0, 16'd4000, 0));
    send_word(pack_word(0, 0, 0, 1, 0, 0, 16'd16384, 0, 0));
    drain();
    write_reg(CFG_INNER, 32'h0005_0000);
    write_reg(CFG_OUTER, 32'h0002_0000);
    send_word(pack_word(0, 0, 0, 32'h0001_0000, 0, 0, 16'd2000, 0, 0));
    send_word(pack_word(0, 0, 0, 32'h0003_0000, 0, 0, 16'd16384, 0, 0));
    send_word(pack_word(0, 0, 0, 32'h0002_0000, 0, 0, 0, 0, 0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) calm = 1;
      write_reg(CFG_INNER, phase == 0 ? 32'hffff_ffff : $urandom_range(0, 32'h0008_0000));
      write_reg(CFG_OUTER, phase == 1 ? 32'd0 : $urandom_range(32'h0001_0000, 32'h0040_0000));
      write_reg(CFG_VOLUME, phase == 2 ? 32'd0 : $urandom_range(0, 16'hffff));
      for (int i = 0; i < 190; i++) begin
        case ($urandom_range(0, 7))
          0: w = 240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom});
          1: w = near_word(1 << 18);
          2: w = near_word(16);
          default: w = near_word(1 << 23);
        endcase
        send_word(w);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
